// ===== hdl/gtc_pkg.sv =====
// shared types, constants and helpers for the generator transfer controller
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package gtc_pkg;

    localparam int LEVEL_BITS_DEF = 8;
    localparam int CFG_BITS       = 8;
    localparam int CNT_BITS       = 9;
    localparam int APB_ADDR_BITS  = 5;
    localparam int APB_DATA_BITS  = 32;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_TDATA_BITS = 16;

    // upper bounds of the temperature / pressure ladder bands
    localparam int TP_BOTH_MAX  = 105;
    localparam int TP_LOWP_MAX  = 135;
    localparam int TP_HIGHT_MAX = 190;

    // register indexes, byte address is four times the index
    localparam logic [2:0] REG_LINE_MIN   = 3'd0;
    localparam logic [2:0] REG_GEN_MIN    = 3'd1;
    localparam logic [2:0] REG_GEN_DEAD   = 3'd2;
    localparam logic [2:0] REG_START_DLY  = 3'd3;
    localparam logic [2:0] REG_RETURN_DLY = 3'd4;
    localparam logic [2:0] REG_RETRY_INT  = 3'd5;

    // temperature / pressure status codes
    localparam logic [2:0] TP_OK          = 3'd0;
    localparam logic [2:0] TP_BOTH        = 3'd1;
    localparam logic [2:0] TP_LOW_PRESS   = 3'd2;
    localparam logic [2:0] TP_HIGH_TEMP   = 3'd3;
    localparam logic [2:0] TP_NOT_CHECKED = 3'd4;

    typedef enum logic [1:0] {
        GEN_NONE = 2'd0,
        GEN_LOW  = 2'd1,
        GEN_GOOD = 2'd2
    } t_gen_class;

    typedef struct packed {
        logic [CFG_BITS-1:0] line_min;
        logic [CFG_BITS-1:0] gen_min;
        logic [CFG_BITS-1:0] gen_dead;
        logic [CFG_BITS-1:0] start_dly;
        logic [CFG_BITS-1:0] return_dly;
        logic [CFG_BITS-1:0] retry_int;
    } t_cfg;

    // one classified polling pass
    typedef struct packed {
        logic       line_ok;
        t_gen_class gen_class;
        logic [2:0] tp_class;
    } t_pass;

    // result beat, generator_in_use in the lowest bit
    typedef struct packed {
        logic [2:0] tp_status;
        logic       start_failed;
        logic       voltage_fault;
        logic       alarm_on;
        logic       fault_latched;
        logic       return_seq;
        logic       restart_seq;
        logic       start_seq;
        logic       gen_in_use;
    } t_result;

    function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] v);
        logic [CNT_BITS-1:0] r;
        r = (&v) ? v : v + CNT_BITS'(1);
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/gtc_regs.sv =====
// configuration register file behind the apb-style port
// depends on gtc_pkg
`timescale 1ns / 1ps
`default_nettype none

module gtc_regs (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [gtc_pkg::APB_ADDR_BITS-1:0] paddr,
    input  wire logic [gtc_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic      [gtc_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                                   pready,
    output gtc_pkg::t_cfg                          o_cfg
);
    import gtc_pkg::*;

    t_cfg                r_cfg;
    logic [2:0]          idx;
    logic [CFG_BITS-1:0] wval;
    logic [CFG_BITS-1:0] rval;
    logic                wr;

    assign idx    = paddr[APB_ADDR_BITS-1:2];
    assign wval   = pwdata[CFG_BITS-1:0];
    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_min   <= CFG_BITS'(113);
            r_cfg.gen_min    <= CFG_BITS'(113);
            r_cfg.gen_dead   <= CFG_BITS'(50);
            r_cfg.start_dly  <= CFG_BITS'(4);
            r_cfg.return_dly <= CFG_BITS'(45);
            r_cfg.retry_int  <= CFG_BITS'(60);
        end else if (wr) begin
            case (idx)
                REG_LINE_MIN:   r_cfg.line_min   <= wval;
                REG_GEN_MIN:    r_cfg.gen_min    <= wval;
                REG_GEN_DEAD:   r_cfg.gen_dead   <= wval;
                REG_START_DLY:  r_cfg.start_dly  <= wval;
                REG_RETURN_DLY: r_cfg.return_dly <= wval;
                REG_RETRY_INT:  r_cfg.retry_int  <= wval;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_LINE_MIN:   rval = r_cfg.line_min;
            REG_GEN_MIN:    rval = r_cfg.gen_min;
            REG_GEN_DEAD:   rval = r_cfg.gen_dead;
            REG_START_DLY:  rval = r_cfg.start_dly;
            REG_RETURN_DLY: rval = r_cfg.return_dly;
            REG_RETRY_INT:  rval = r_cfg.retry_int;
            default:        rval = '0;
        endcase
    end

    assign prdata = APB_DATA_BITS'(rval);
    assign o_cfg  = r_cfg;

endmodule

`default_nettype wire

// ===== hdl/gtc_front.sv =====
// front end: takes input beats and classifies the three sampled levels
// depends on gtc_pkg
`timescale 1ns / 1ps
`default_nettype none

module gtc_front #(
    parameter int LEVEL_BITS = gtc_pkg::LEVEL_BITS_DEF
) (
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [LEVEL_BITS-1:0] i_line,
    input  wire logic [LEVEL_BITS-1:0] i_gen,
    input  wire logic [LEVEL_BITS-1:0] i_tp,
    input  wire gtc_pkg::t_cfg         i_cfg,
    input  wire logic                  i_full,
    output logic                       o_push,
    output gtc_pkg::t_pass             o_pass
);
    import gtc_pkg::*;

    logic [LEVEL_BITS-1:0] line_min;
    logic [LEVEL_BITS-1:0] gen_min;
    logic [LEVEL_BITS-1:0] gen_dead;

    assign line_min = LEVEL_BITS'(i_cfg.line_min);
    assign gen_min  = LEVEL_BITS'(i_cfg.gen_min);
    assign gen_dead = LEVEL_BITS'(i_cfg.gen_dead);

    assign o_ready = ~i_full;
    assign o_push  = i_valid & ~i_full;

    always_comb begin
        o_pass.line_ok = (i_line >= line_min);

        // dead level wins over minimum level whatever the register order
        if (i_gen < gen_dead)     o_pass.gen_class = GEN_NONE;
        else if (i_gen < gen_min) o_pass.gen_class = GEN_LOW;
        else                      o_pass.gen_class = GEN_GOOD;

        if (i_tp <= LEVEL_BITS'(TP_BOTH_MAX))       o_pass.tp_class = TP_BOTH;
        else if (i_tp <= LEVEL_BITS'(TP_LOWP_MAX))  o_pass.tp_class = TP_LOW_PRESS;
        else if (i_tp <= LEVEL_BITS'(TP_HIGHT_MAX)) o_pass.tp_class = TP_HIGH_TEMP;
        else                                        o_pass.tp_class = TP_OK;
    end

endmodule

`default_nettype wire

// ===== hdl/gtc_queue.sv =====
// short queue of classified passes between front and back end
// depends on gtc_pkg
`timescale 1ns / 1ps
`default_nettype none

module gtc_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire gtc_pkg::t_pass i_data,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output gtc_pkg::t_pass      o_data
);
    import gtc_pkg::*;

    t_pass                r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QCNT_BITS-1:0] r_count;
    logic                 do_pop;

    assign o_full  = (r_count == QCNT_BITS'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop & o_valid;

    function automatic logic [QPTR_BITS-1:0] ptr_next(input logic [QPTR_BITS-1:0] p);
        logic [QPTR_BITS-1:0] r;
        r = (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_BITS'(1);
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= ptr_next(r_wr_ptr);
            if (do_pop) r_rd_ptr <= ptr_next(r_rd_ptr);
            if (i_push && !do_pop)      r_count <= r_count + QCNT_BITS'(1);
            else if (!i_push && do_pop) r_count <= r_count - QCNT_BITS'(1);
        end
    end

endmodule

`default_nettype wire

// ===== hdl/gtc_back.sv =====
// back end: transfer mode state, retry and fault latches, result register
// depends on gtc_pkg
`timescale 1ns / 1ps
`default_nettype none

module gtc_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire gtc_pkg::t_cfg  i_cfg,
    input  wire logic           i_q_valid,
    input  wire gtc_pkg::t_pass i_pass,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_ready,
    output gtc_pkg::t_result    o_result
);
    import gtc_pkg::*;

    logic                r_on;
    logic [CNT_BITS-1:0] r_low;
    logic [CNT_BITS-1:0] r_back;
    logic [CNT_BITS-1:0] r_retry;
    logic                r_fault;
    logic                r_alarm;
    logic                r_vfault;
    logic                r_sfail;
    logic                r_valid;
    t_result             r_result;

    logic                n_on;
    logic [CNT_BITS-1:0] n_low;
    logic [CNT_BITS-1:0] n_back;
    logic [CNT_BITS-1:0] n_retry;
    logic                n_fault;
    logic                n_alarm;
    logic                n_vfault;
    logic                n_sfail;
    t_result             n_result;

    logic                start_req;
    logic                restart_req;
    logic                return_req;
    logic                check_gen;
    logic [2:0]          tp_status;
    logic [CNT_BITS-1:0] low_inc;
    logic [CNT_BITS-1:0] back_inc;
    logic [CNT_BITS-1:0] retry_inc;
    logic [CNT_BITS-1:0] two_int;

    assign o_pop    = i_q_valid & (~r_valid | i_ready);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    assign low_inc   = sat_inc(r_low);
    assign back_inc  = sat_inc(r_back);
    assign retry_inc = sat_inc(r_retry);
    assign two_int   = {i_cfg.retry_int, 1'b0};

    always_comb begin
        n_on        = r_on;
        n_low       = r_low;
        n_back      = r_back;
        n_retry     = r_retry;
        n_fault     = r_fault;
        n_alarm     = r_alarm;
        n_vfault    = r_vfault;
        n_sfail     = r_sfail;
        start_req   = 1'b0;
        restart_req = 1'b0;
        return_req  = 1'b0;
        check_gen   = 1'b0;
        tp_status   = TP_NOT_CHECKED;

        // mode transfer
        if (i_pass.line_ok) begin
            if (r_on) begin
                if (back_inc > CNT_BITS'(i_cfg.return_dly)) begin
                    n_back     = '0;
                    n_on       = 1'b0;
                    return_req = 1'b1;
                end else begin
                    n_back    = back_inc;
                    check_gen = 1'b1;
                end
            end else begin
                n_low = '0;
            end
        end else begin
            if (r_on) begin
                n_back    = '0;
                check_gen = 1'b1;
            end else if (low_inc > CNT_BITS'(i_cfg.start_dly) && !r_fault) begin
                n_low     = '0;
                n_on      = 1'b1;
                start_req = 1'b1;
            end else begin
                n_low = low_inc;
            end
        end

        // generator checks; alarm is always set along with the shutdown fault
        if (check_gen) begin
            case (i_pass.gen_class)
                GEN_NONE: begin
                    n_retry = retry_inc;
                    if (retry_inc == CNT_BITS'(i_cfg.retry_int) || retry_inc == two_int) begin
                        restart_req = 1'b1;
                        n_alarm     = 1'b1;
                    end
                    if (retry_inc > two_int) begin
                        n_fault = 1'b1;
                        n_alarm = 1'b1;
                        n_sfail = 1'b1;
                    end
                end
                GEN_LOW: begin
                    n_fault  = 1'b1;
                    n_alarm  = 1'b1;
                    n_vfault = 1'b1;
                end
                GEN_GOOD: begin
                    n_retry = '0;
                    if (!r_fault) begin
                        tp_status = i_pass.tp_class;
                        if (i_pass.tp_class != TP_OK) begin
                            n_fault = 1'b1;
                            n_alarm = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end

        n_result.tp_status     = tp_status;
        n_result.start_failed  = n_sfail;
        n_result.voltage_fault = n_vfault;
        n_result.alarm_on      = n_alarm;
        n_result.fault_latched = n_fault;
        n_result.return_seq    = return_req;
        n_result.restart_seq   = restart_req;
        n_result.start_seq     = start_req;
        n_result.gen_in_use    = n_on;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on     <= 1'b0;
            r_low    <= '0;
            r_back   <= '0;
            r_retry  <= '0;
            r_fault  <= 1'b0;
            r_alarm  <= 1'b0;
            r_vfault <= 1'b0;
            r_sfail  <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_on     <= n_on;
                r_low    <= n_low;
                r_back   <= n_back;
                r_retry  <= n_retry;
                r_fault  <= n_fault;
                r_alarm  <= n_alarm;
                r_vfault <= n_vfault;
                r_sfail  <= n_sfail;
                r_valid  <= 1'b1;
            end else if (i_ready) begin
                r_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= n_result;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/generator_transfer_controller.sv =====
// top level of the generator transfer controller: register file, front end,
// pass queue and back end; depends on gtc_pkg, gtc_regs, gtc_front,
// gtc_queue and gtc_back
//
// usage
//   each beat on the s_axis side is one polling pass: mains, generator and
//   temperature/pressure levels; each pass gives exactly one result beat on
//   the m_axis side, in order
//   the front end classifies the levels against the registers and writes the
//   pass into a four-entry queue; the back end runs the mains/generator mode,
//   saturating pass counters and fault latches, one pass per unstalled cycle
//   path: the pass is registered in a queue entry and then in the result
//   register, which drives the result beat
//   throughput: one pass per cycle while the receiver takes the result beats,
//   set by the state update of the back end
//   receiver stall: the result register holds its beat, the back end stops
//   and the queue fills; s_axis_tready drops only once the queue is full
//   reset (synchronous, active low): mode on mains, counters and latches
//   cleared, queue empty, registers at their defaults; the user must have the
//   registers written only while no pass is in flight; block does not enforce
`timescale 1ns / 1ps
`default_nettype none

module generator_transfer_controller #(
    parameter int LEVEL_BITS = gtc_pkg::LEVEL_BITS_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // apb-style configuration port, register i at byte address 4*i
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [gtc_pkg::APB_ADDR_BITS-1:0]      paddr,
    input  wire logic [gtc_pkg::APB_DATA_BITS-1:0]      pwdata,
    output logic      [gtc_pkg::APB_DATA_BITS-1:0]      prdata,
    output logic                                        pready,
    // polling pass input
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    // line_level, generator_level, temp_pressure_level, zero padding
    input  wire logic [((3*LEVEL_BITS+7)/8)*8-1:0]      s_axis_tdata,
    // result output
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    // generator_in_use, start_sequence, restart_sequence, return_sequence,
    // fault_latched, alarm_on, generator_voltage_fault, start_failed,
    // temp_pressure_status[2:0], zero padding
    output logic      [gtc_pkg::OUT_TDATA_BITS-1:0]     m_axis_tdata
);
    import gtc_pkg::*;

    t_cfg    cfg;
    t_pass   front_pass;
    t_pass   queue_pass;
    t_result result;
    logic    q_full;
    logic    q_valid;
    logic    push;
    logic    pop;

    gtc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // classification needs only the levels and the registers
    gtc_front #(
        .LEVEL_BITS (LEVEL_BITS)
    ) u_front (
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_line  (s_axis_tdata[LEVEL_BITS-1:0]),
        .i_gen   (s_axis_tdata[2*LEVEL_BITS-1:LEVEL_BITS]),
        .i_tp    (s_axis_tdata[3*LEVEL_BITS-1:2*LEVEL_BITS]),
        .i_cfg   (cfg),
        .i_full  (q_full),
        .o_push  (push),
        .o_pass  (front_pass)
    );

    gtc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_pass),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (queue_pass)
    );

    // mode, counters and latches; the result register parts it from the sink
    gtc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_pass    (queue_pass),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_result  (result)
    );

    assign m_axis_tdata = OUT_TDATA_BITS'(result);

endmodule

`default_nettype wire

// ===== hdl/gtc_checker.sv =====
// port-level checks for the generator transfer controller, bound to the top
// depends on gtc_pkg and generator_transfer_controller
`timescale 1ns / 1ps
`default_nettype none

module gtc_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               m_axis_tvalid,
    input wire logic                               m_axis_tready,
    input wire logic [gtc_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata
);
    import gtc_pkg::*;

    // no result beat straight after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat valid after reset");

    // a start request moves the load onto the generator in the same beat
    a_start_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[1]) |-> m_axis_tdata[0])
        else $error("start request without generator mode");

    // start, restart and return requests never coincide
    a_req_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $onehot0(m_axis_tdata[3:1]))
        else $error("more than one sequence request in one beat");

    // a latched shutdown fault always comes with the alarm
    a_fault_alarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[4]) |-> m_axis_tdata[5])
        else $error("fault latched without alarm");

    // a stalled result beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result beat changed");

endmodule

bind generator_transfer_controller gtc_checker u_gtc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== verif/tb.sv =====
// self-checking bench for generator_transfer_controller: polling passes go in
// on the stream input, result beats are checked against an in-bench mode tracker
// depends on gtc_pkg and the block's top level
`timescale 1ns / 1ps

module tb;
    import gtc_pkg::*;

    localparam int CYCLE_LIMIT = 150000;
    // upper bounds of the temperature / pressure ladder bands
    localparam int BAND_BOTH_TOP  = 105;
    localparam int BAND_PRESS_TOP = 135;
    localparam int BAND_TEMP_TOP  = 190;
    localparam int COUNT_TOP      = 511;

    // tracks the controller mode pass by pass and holds the results still due
    class mode_checker;
        bit [7:0] line_min, gen_min, gen_dead, start_dly, return_dly, retry_int;
        bit       on_gen, shut, alarm, vfault, failed;
        bit [8:0] low_cnt, back_cnt, retry_cnt;
        t_result  status_due[$];
        int       errors, passes, checked, starts, returns, restarts;

        function new();
            line_min   = 8'd113;
            gen_min    = 8'd113;
            gen_dead   = 8'd50;
            start_dly  = 8'd4;
            return_dly = 8'd45;
            retry_int  = 8'd60;
        endfunction

        function void set_reg(logic [2:0] idx, bit [7:0] value);
            case (idx)
                REG_LINE_MIN:   line_min   = value;
                REG_GEN_MIN:    gen_min    = value;
                REG_GEN_DEAD:   gen_dead   = value;
                REG_START_DLY:  start_dly  = value;
                REG_RETURN_DLY: return_dly = value;
                REG_RETRY_INT:  retry_int  = value;
                default: ;
            endcase
        endfunction

        function bit [8:0] bump(bit [8:0] v);
            return (v >= COUNT_TOP) ? 9'(COUNT_TOP) : v + 9'd1;
        endfunction

        function void trip();
            if (!shut) begin
                alarm = 1'b1;
                shut  = 1'b1;
            end
        endfunction

        function void take_pass(bit [7:0] line, bit [7:0] gen, bit [7:0] tp);
            t_result r;
            bit      check;
            int      twice;
            r = '0;
            r.tp_status = TP_NOT_CHECKED;
            check = 1'b0;
            if (line >= line_min) begin
                if (on_gen) begin
                    back_cnt = bump(back_cnt);
                    if (back_cnt > return_dly) begin
                        back_cnt = '0;
                        on_gen = 1'b0;
                        r.return_seq = 1'b1;
                    end else begin
                        check = 1'b1;
                    end
                end else begin
                    low_cnt = '0;
                end
            end else begin
                if (on_gen) begin
                    back_cnt = '0;
                    check = 1'b1;
                end else begin
                    low_cnt = bump(low_cnt);
                    if (low_cnt > start_dly && !shut) begin
                        low_cnt = '0;
                        on_gen = 1'b1;
                        r.start_seq = 1'b1;
                    end
                end
            end
            if (check) begin
                if (gen < gen_dead) begin
                    twice = 2 * int'(retry_int);
                    retry_cnt = bump(retry_cnt);
                    if (int'(retry_cnt) == int'(retry_int) || int'(retry_cnt) == twice) begin
                        r.restart_seq = 1'b1;
                        alarm = 1'b1;
                    end
                    if (int'(retry_cnt) >= twice + 1) begin
                        trip();
                        failed = 1'b1;
                    end
                end else if (gen < gen_min) begin
                    trip();
                    vfault = 1'b1;
                end else begin
                    retry_cnt = '0;
                    if (!shut) begin
                        if (tp <= BAND_BOTH_TOP)       r.tp_status = TP_BOTH;
                        else if (tp <= BAND_PRESS_TOP) r.tp_status = TP_LOW_PRESS;
                        else if (tp <= BAND_TEMP_TOP)  r.tp_status = TP_HIGH_TEMP;
                        else                           r.tp_status = TP_OK;
                        if (r.tp_status != TP_OK) trip();
                    end
                end
            end
            r.gen_in_use    = on_gen;
            r.fault_latched = shut;
            r.alarm_on      = alarm;
            r.voltage_fault = vfault;
            r.start_failed  = failed;
            starts   += r.start_seq;
            returns  += r.return_seq;
            restarts += r.restart_seq;
            passes++;
            status_due.push_back(r);
        endfunction

        function void field(string name, int want, int got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_status(logic [OUT_TDATA_BITS-1:0] beat);
            t_result want, got;
            if (status_due.size() == 0) begin
                errors++;
                $display("%0t: result beat with nothing due, expected none actual %h",
                         $time, beat);
                return;
            end
            want = status_due.pop_front();
            got  = t_result'(beat[$bits(t_result)-1:0]);
            checked++;
            field("generator_in_use", want.gen_in_use, got.gen_in_use);
            field("start_sequence", want.start_seq, got.start_seq);
            field("restart_sequence", want.restart_seq, got.restart_seq);
            field("return_sequence", want.return_seq, got.return_seq);
            field("fault_latched", want.fault_latched, got.fault_latched);
            field("alarm_on", want.alarm_on, got.alarm_on);
            field("generator_voltage_fault", want.voltage_fault, got.voltage_fault);
            field("start_failed", want.start_failed, got.start_failed);
            field("temp_pressure_status", want.tp_status, got.tp_status);
            field("padding", 0, int'(beat[OUT_TDATA_BITS-1:$bits(t_result)]));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic        pready;
    logic        s_axis_tvalid, s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid, m_axis_tready;
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;

    mode_checker board = new();
    bit  steady;            // no idling on either side while set
    int  hold_request;      // receiver hold-off length, picked up by the sink
    int  dead_left;         // dead-generator passes still wanted in a stretch
    int  settings;

    generator_transfer_controller i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // result side: check accepted beats, random stalls and one long hold-off
    initial begin : sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                board.check_status(m_axis_tdata);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (steady) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= 15);
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results still due", cycles,
                 board.status_due.size());
        $display("FAIL generator_transfer_controller");
        $finish;
    end

    // one polling pass beat, taken when tready is seen high at an edge
    task automatic send_pass(input bit [7:0] line, input bit [7:0] gen, input bit [7:0] tp);
        if (!steady && $urandom_range(99) < 15) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(2, 1)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {tp, gen, line};
        do @(posedge i_clk); while (!s_axis_tready);
        board.take_pass(line, gen, tp);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (board.status_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [2:0] idx, input bit [7:0] value);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DATA_BITS'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        board.set_reg(idx, value);
    endtask

    task automatic configure(input bit [7:0] line_min, input bit [7:0] gen_min,
                             input bit [7:0] gen_dead, input bit [7:0] start_dly,
                             input bit [7:0] return_dly, input bit [7:0] retry_int);
        set_reg(REG_LINE_MIN, line_min);
        set_reg(REG_GEN_MIN, gen_min);
        set_reg(REG_GEN_DEAD, gen_dead);
        set_reg(REG_START_DLY, start_dly);
        set_reg(REG_RETURN_DLY, return_dly);
        set_reg(REG_RETRY_INT, retry_int);
        dead_left = 0;
        settings++;
    endtask

    function automatic bit flicker(input bit quiet);
        return !quiet && ($urandom_range(15) == 0);
    endfunction

    // a pass that never latches a fault: levels that are looked at stay in
    // the good or dead band, everything ignored by the block is random
    task automatic safe_pass(input bit want_mains);
        bit [7:0] line, gen, tp, lo;
        bit       present, check;
        if (want_mains || board.line_min == 0)
            line = 8'($urandom_range(255, board.line_min));
        else
            line = 8'($urandom_range(board.line_min - 1, 0));
        present = (line >= board.line_min);
        check = board.on_gen &&
                !(present && int'(board.back_cnt) + 1 > int'(board.return_dly));
        gen = 8'($urandom_range(255));
        tp  = 8'($urandom_range(255));
        if (check) begin
            if (dead_left == 0 && $urandom_range(9) == 0)
                dead_left = $urandom_range(2 * int'(board.retry_int), 1);
            if (dead_left > 0 && board.gen_dead > 0 &&
                int'(board.retry_cnt) + 1 <= 2 * int'(board.retry_int)) begin
                gen = 8'($urandom_range(board.gen_dead - 1, 0));
                dead_left--;
            end else begin
                lo  = (board.gen_dead > board.gen_min) ? board.gen_dead : board.gen_min;
                gen = 8'($urandom_range(255, lo));
                tp  = 8'($urandom_range(255, BAND_TEMP_TOP + 1));
                dead_left = 0;
            end
        end
        send_pass(line, gen, tp);
    endtask

    // mains outage then recovery, each either short of or past its delay
    task automatic episode(input bit force_long);
        int n_low, n_high, k;
        if (force_long || $urandom_range(2) != 0)
            n_low = int'(board.start_dly) + 1 + $urandom_range(12);
        else
            n_low = $urandom_range(board.start_dly);
        for (k = 0; k < n_low; k++) safe_pass(flicker(force_long));
        if (force_long || $urandom_range(2) != 0)
            n_high = int'(board.return_dly) + 1 + $urandom_range(6);
        else
            n_high = $urandom_range(board.return_dly);
        for (k = 0; k < n_high; k++) safe_pass(!flicker(force_long));
    endtask

    task automatic run_phase(input int n);
        int stop;
        stop = board.passes + n;
        while (board.passes < stop) episode(1'b0);
    endtask

    initial begin : stimulus
        bit [7:0] band_edge [6];
        int k;
        band_edge = '{8'd0, 8'd105, 8'd106, 8'd135, 8'd136, 8'd190};
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        steady = 1'b0;
        hold_request = 0;
        dead_left = 0;
        settings = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: short delays so starts and returns come quickly
        configure(8'd113, 8'd113, 8'd50, 8'd1, 8'd1, 8'd2);
        send_pass(8'd0, 8'd255, 8'd0);      // mains low, levels ignored on mains
        send_pass(8'd112, 8'd80, 8'd0);     // start pass, low voltage not looked at
        send_pass(8'd0, 8'd255, 8'd191);    // just above the high temperature band
        send_pass(8'd112, 8'd113, 8'd255);  // generator exactly at minimum
        send_pass(8'd0, 8'd49, 8'd0);       // dead, first retry
        send_pass(8'd0, 8'd0, 8'd255);      // one interval, restart
        send_pass(8'd0, 8'd200, 8'd200);    // good voltage clears the retries
        send_pass(8'd113, 8'd0, 8'd0);      // mains back, still checked
        send_pass(8'd255, 8'd80, 8'd0);     // return pass, no checks
        send_pass(8'd0, 8'd0, 8'd0);
        send_pass(8'd255, 8'd255, 8'd255);  // mains back on mains, count cleared
        send_pass(8'd0, 8'd0, 8'd0);
        send_pass(8'd1, 8'd0, 8'd0);        // start
        send_pass(8'd255, 8'd255, 8'd255);
        send_pass(8'd0, 8'd255, 8'd255);    // mains low again, back count cleared
        send_pass(8'd255, 8'd255, 8'd255);
        send_pass(8'd113, 8'd0, 8'd0);      // return
        send_pass(8'd0, 8'd0, 8'd0);
        send_pass(8'd0, 8'd0, 8'd0);        // start
        for (k = 0; k < 4; k++)
            send_pass(8'd0, 8'd0, 8'd0);    // restarts at one and two intervals
        send_pass(8'd0, 8'd255, 8'd255);

        // reset values, with the receiver held off so the input backs up
        configure(8'd113, 8'd113, 8'd50, 8'd4, 8'd45, 8'd60);
        hold_request = 200;
        run_phase(80);

        // tight delays, no idling on either side
        steady = 1'b1;
        configure(8'd128, 8'd90, 8'd40, 8'd0, 8'd0, 8'd1);
        run_phase(50);
        steady = 1'b0;

        // random settings, levels in any order
        for (k = 0; k < 4; k++) begin
            configure(8'($urandom_range(255, 1)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 8'($urandom_range(6)),
                      8'($urandom_range(6)), 8'($urandom_range(6, 1)));
            run_phase(20);
        end

        // lowest settings: mains always present
        configure(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1);
        run_phase(10);

        // highest settings, one long outage and recovery
        configure(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        episode(1'b1);

        // faults last, since only a reset clears the latches
        configure(8'd113, 8'd150, 8'd60, 8'd0, 8'd3, 8'd2);
        while (!board.on_gen) send_pass(8'd0, 8'd200, 8'd191);
        send_pass(8'd0, 8'd200, 8'd191);
        send_pass(8'd0, 8'd200, band_edge[$urandom_range(5)]);  // ladder band trips
        send_pass(8'd0, 8'd100, 8'd0);      // low voltage latch
        send_pass(8'd0, 8'd255, 8'd0);      // no ladder check once tripped
        set_reg(REG_RETRY_INT, 8'd0);
        send_pass(8'd0, 8'd10, 8'd77);      // zero interval fails at once
        set_reg(REG_RETRY_INT, 8'd2);
        for (k = 0; k < 515; k++)           // retry count runs into saturation
            send_pass(8'($urandom_range(112)), 8'($urandom_range(59)),
                      8'($urandom_range(255)));
        for (k = 0; k < 4; k++)
            send_pass(8'($urandom_range(255, 113)), 8'($urandom_range(255)),
                      8'($urandom_range(255)));
        for (k = 0; k < 520; k++)           // start blocked, low count saturates
            send_pass(8'($urandom_range(112)), 8'($urandom_range(255)),
                      8'($urandom_range(255)));
        for (k = 0; k < 8; k++)
            send_pass(8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)));

        wait_idle();
        repeat (4) @(posedge i_clk);
        $display("%0d passes over %0d register settings, %0d results checked",
                 board.passes, settings, board.checked);
        $display("%0d starts, %0d returns, %0d restarts, %0d mismatches",
                 board.starts, board.returns, board.restarts, board.errors);
        if (board.errors == 0 && board.status_due.size() == 0) begin
            $display("PASS generator_transfer_controller");
        end else begin
            $display("FAIL generator_transfer_controller");
        end
        $finish;
    end

endmodule

// ===== generator_transfer_controller.f =====
hdl/gtc_pkg.sv
hdl/gtc_regs.sv
hdl/gtc_front.sv
hdl/gtc_queue.sv
hdl/gtc_back.sv
hdl/generator_transfer_controller.sv
hdl/gtc_checker.sv
verif/tb.sv
